@@ design/multilevel_queue_scheduler_top_defines.svh @@
// Assertion macros used by the scheduler top level.
`ifndef MULTILEVEL_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("Scheduler assertion failed.");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("Scheduler assertion failed.");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ design/mlqs_pkg.sv @@
// Package with the types, constants and codes of the multilevel queue scheduler.
`timescale 1ns / 1ps
package mlqs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int SLOT_W    = $clog2(MAX_PROCS);
    localparam int PTR_W     = SLOT_W + 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int PID_W     = 4;
    localparam int TIME_W    = 16;
    localparam int SLICE_W   = 16;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd2;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;
    localparam logic LEVEL_HIGH  = 1'b0;
    localparam logic LEVEL_LOW   = 1'b1;

    typedef struct packed {
        logic              command;
        logic [PID_W-1:0]  process_id;
        logic [TIME_W-1:0] burst_length;
        logic              queue_level;
    } sched_in_t;

    typedef struct packed {
        logic              idle;
        logic [PID_W-1:0]  running_id;
        logic              running_level;
        logic              first_run;
        logic [TIME_W-1:0] response_time;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
        logic              slice_expired;
    } sched_out_t;

    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] stamp;
        logic              started;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef struct packed {
        logic arrive;
        logic pick;
        logic fetch;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ design/multilevel_queue_scheduler_top.sv @@
// An arrival request is handled in the cycle it is accepted; the next request is accepted in the following cycle.
// A tick request goes through a queue read, a slot table read and an update, and its result
// is held in the result register after the update; a new request is accepted once the update is done.
// The update waits while the result register holds a result that is stalled.
// Reset (rst_n, asynchronous, active low) clears time, queues, busy slots and the result valid flag.
// The slot table RAM is not cleared; each slot is written on arrival before it is read.
`timescale 1ns / 1ps
`include "multilevel_queue_scheduler_top_defines.svh"
module multilevel_queue_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mlqs_pkg::sched_in_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mlqs_pkg::sched_out_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mlqs_pkg::SLICE_W-1:0]  cfg_data
);

    import mlqs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       cfg_write;
    logic       tick_accept;
    logic       arrival_accept;

    assign cfg_ready      = 1'b1;
    assign cfg_write      = cfg_valid && cfg_ready;
    assign tick_accept    = in_valid && !in_stall && (in_data.command == CMD_TICK);
    assign arrival_accept = in_valid && !in_stall && (in_data.command == CMD_ARRIVAL);

    mlqs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .status     (status),
        .in_stall   (in_stall),
        .cmd        (cmd)
    );

    mlqs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_valid (cfg_write),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .status    (status)
    );

    // A tick request keeps the input side busy while it is scheduled.
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, tick_accept, in_stall)
    `ASSERT_NEXT(a_arrival_single, clk, rst_n, arrival_accept, !in_stall)
    // A fresh result always stems from an earlier tick request.
    `ASSERT_IMPLIES(a_result_origin, clk, rst_n, $rose(out_valid), $past(tick_accept, 3))

endmodule

@@ design/mlqs_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module mlqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/mlqs_ctrl.sv @@
// Controller state machine that sequences arrival and tick requests.
`timescale 1ns / 1ps
module mlqs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    input  mlqs_pkg::dp_status_t status,
    output logic                in_stall,
    output mlqs_pkg::ctrl_cmd_t  cmd
);

    import mlqs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_command == CMD_TICK)
                    begin
                        cmd.pick   = 1'b1;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        cmd.arrive = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/mlqs_datapath.sv @@
// Datapath with the slot table, both ready queues, timing state and result register.
`timescale 1ns / 1ps
module mlqs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mlqs_pkg::ctrl_cmd_t            cmd,
    input  mlqs_pkg::sched_in_t            in_data,
    input  logic                          cfg_valid,
    input  logic [mlqs_pkg::SLICE_W-1:0]  cfg_data,
    input  logic                          out_stall,
    output logic                          out_valid,
    output mlqs_pkg::sched_out_t           out_data,
    output mlqs_pkg::dp_status_t           status
);

    import mlqs_pkg::*;

    typedef enum logic [1:0] {
        SRC_NONE = 2'b00,
        SRC_KEEP = 2'b01,
        SRC_HIGH = 2'b10,
        SRC_LOW  = 2'b11
    } src_t;

    function automatic logic [SLOT_W-1:0] ptr_inc(input logic [SLOT_W-1:0] p);
        if (32'(p) == MAX_PROCS - 1)
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] ptr_dec(input logic [SLOT_W-1:0] p);
        if (p == '0)
        begin
            return SLOT_W'(MAX_PROCS - 1);
        end
        return p - 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] ptr_tail(input logic [SLOT_W-1:0] head,
                                                   input logic [CNT_W-1:0]  count);
        logic [PTR_W-1:0] sum;
        sum = PTR_W'(head) + PTR_W'(count);
        if (sum >= PTR_W'(MAX_PROCS))
        begin
            sum = sum - PTR_W'(MAX_PROCS);
        end
        return sum[SLOT_W-1:0];
    endfunction

    logic [SLICE_W-1:0]   slice_length_reg, slice_length_next;
    logic [TIME_W-1:0]    current_time_reg, current_time_next;
    logic [SLOT_W-1:0]    running_slot_reg, running_slot_next;
    logic                 running_valid_reg, running_valid_next;
    logic                 running_level_reg, running_level_next;
    logic [SLICE_W-1:0]   slice_used_reg, slice_used_next;
    logic [MAX_PROCS-1:0] busy_reg, busy_next;
    logic [SLOT_W-1:0]    hq_head_reg, hq_head_next;
    logic [CNT_W-1:0]     hq_count_reg, hq_count_next;
    logic [SLOT_W-1:0]    lq_head_reg, lq_head_next;
    logic [CNT_W-1:0]     lq_count_reg, lq_count_next;
    src_t                 src_reg, src_next;
    logic                 out_valid_reg, out_valid_next;
    sched_out_t           out_data_reg, out_data_next;

    logic                 hq_wr_en, hq_rd_en;
    logic [SLOT_W-1:0]    hq_wr_addr, hq_wr_data, hq_rd_data;
    logic                 lq_wr_en, lq_rd_en;
    logic [SLOT_W-1:0]    lq_wr_addr, lq_wr_data, lq_rd_data;
    logic                 tbl_wr_en, tbl_rd_en;
    logic [SLOT_W-1:0]    tbl_wr_addr, tbl_rd_addr;
    logic [ENTRY_W-1:0]   tbl_wr_data, tbl_rd_data;

    logic [SLOT_W-1:0]    arr_slot;
    logic                 arr_ok;
    logic                 preempt, keep, pop_high, pop_low;
    logic [SLOT_W-1:0]    fetch_slot;
    slot_entry_t          entry, entry_new;
    logic [TIME_W-1:0]    rem_dec, time_inc;
    logic [SLICE_W-1:0]   su_inc, quantum;
    logic                 done, expire;

    assign arr_slot = SLOT_W'(in_data.process_id);
    assign arr_ok   = (32'(in_data.process_id) < MAX_PROCS)
                      && (in_data.burst_length != '0) && !busy_reg[arr_slot];

    assign preempt  = running_valid_reg && (running_level_reg == LEVEL_LOW)
                      && (hq_count_reg != '0);
    assign keep     = running_valid_reg && !preempt;
    assign pop_high = !keep && (hq_count_reg != '0);
    assign pop_low  = !keep && (hq_count_reg == '0) && (lq_count_reg != '0);

    always_comb
    begin
        unique case (src_reg)
            SRC_HIGH: fetch_slot = hq_rd_data;
            SRC_LOW:  fetch_slot = lq_rd_data;
            default:  fetch_slot = running_slot_reg;
        endcase
    end

    assign entry    = slot_entry_t'(tbl_rd_data);
    assign rem_dec  = entry.remaining - 16'd1;
    assign time_inc = current_time_reg + 16'd1;
    assign su_inc   = ((running_level_reg == LEVEL_HIGH) && (slice_used_reg != 16'hFFFF))
                      ? slice_used_reg + 16'd1 : slice_used_reg;
    assign quantum  = (slice_length_reg == '0) ? 16'd1 : slice_length_reg;
    assign done     = (rem_dec == '0);
    assign expire   = !done && (running_level_reg == LEVEL_HIGH) && (su_inc >= quantum);

    always_comb
    begin
        slice_length_next  = slice_length_reg;
        current_time_next  = current_time_reg;
        running_slot_next  = running_slot_reg;
        running_valid_next = running_valid_reg;
        running_level_next = running_level_reg;
        slice_used_next    = slice_used_reg;
        busy_next          = busy_reg;
        hq_head_next       = hq_head_reg;
        hq_count_next      = hq_count_reg;
        lq_head_next       = lq_head_reg;
        lq_count_next      = lq_count_reg;
        src_next           = src_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_data_next      = '0;

        hq_wr_en    = 1'b0;
        hq_wr_addr  = ptr_tail(hq_head_reg, hq_count_reg);
        hq_wr_data  = arr_slot;
        hq_rd_en    = 1'b0;
        lq_wr_en    = 1'b0;
        lq_wr_addr  = ptr_tail(lq_head_reg, lq_count_reg);
        lq_wr_data  = arr_slot;
        lq_rd_en    = 1'b0;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = arr_slot;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = fetch_slot;
        entry_new   = '{remaining: in_data.burst_length, stamp: current_time_reg,
                        started: 1'b0};

        if (cfg_valid)
        begin
            slice_length_next = cfg_data;
        end

        if (cmd.arrive && arr_ok)
        begin
            busy_next[arr_slot] = 1'b1;
            tbl_wr_en           = 1'b1;
            if (in_data.queue_level == LEVEL_LOW)
            begin
                lq_wr_en      = 1'b1;
                lq_count_next = lq_count_reg + 1'b1;
            end
            else
            begin
                hq_wr_en      = 1'b1;
                hq_count_next = hq_count_reg + 1'b1;
            end
        end

        if (cmd.pick)
        begin
            // A preempted low level process goes back to the head of its queue.
            if (preempt)
            begin
                lq_wr_en      = 1'b1;
                lq_wr_addr    = ptr_dec(lq_head_reg);
                lq_wr_data    = running_slot_reg;
                lq_head_next  = ptr_dec(lq_head_reg);
                lq_count_next = lq_count_reg + 1'b1;
            end
            running_valid_next = keep || pop_high || pop_low;
            if (keep)
            begin
                src_next = SRC_KEEP;
            end
            else if (pop_high)
            begin
                src_next           = SRC_HIGH;
                hq_rd_en           = 1'b1;
                hq_head_next       = ptr_inc(hq_head_reg);
                hq_count_next      = hq_count_reg - 1'b1;
                running_level_next = LEVEL_HIGH;
                slice_used_next    = '0;
            end
            else if (pop_low)
            begin
                src_next           = SRC_LOW;
                lq_rd_en           = 1'b1;
                lq_head_next       = ptr_inc(lq_head_reg);
                lq_count_next      = lq_count_reg - 1'b1;
                running_level_next = LEVEL_LOW;
                slice_used_next    = '0;
            end
            else
            begin
                src_next = SRC_NONE;
            end
        end

        if (cmd.fetch)
        begin
            tbl_rd_en         = 1'b1;
            running_slot_next = fetch_slot;
        end

        if (cmd.exec)
        begin
            out_valid_next            = 1'b1;
            current_time_next         = time_inc;
            out_data_next.idle        = !running_valid_reg;
            out_data_next.finish_time = time_inc;
            if (running_valid_reg)
            begin
                out_data_next.running_id    = PID_W'(running_slot_reg);
                out_data_next.running_level = running_level_reg;
                out_data_next.first_run     = !entry.started;
                out_data_next.response_time = entry.started ? '0
                                              : current_time_reg - entry.stamp;
                out_data_next.finished      = done;
                out_data_next.slice_expired = expire;

                tbl_wr_en   = 1'b1;
                tbl_wr_addr = running_slot_reg;
                entry_new   = '{remaining: rem_dec, stamp: entry.stamp, started: 1'b1};

                if (done)
                begin
                    busy_next[running_slot_reg] = 1'b0;
                    running_valid_next          = 1'b0;
                    slice_used_next             = '0;
                end
                else if (expire)
                begin
                    hq_wr_en           = 1'b1;
                    hq_wr_data         = running_slot_reg;
                    hq_count_next      = hq_count_reg + 1'b1;
                    running_valid_next = 1'b0;
                    slice_used_next    = '0;
                end
                else
                begin
                    slice_used_next = su_inc;
                end
            end
        end

        tbl_wr_data = ENTRY_W'(entry_new);
    end

    mlqs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_PROCS)) u_high_queue (
        .clk     (clk),
        .wr_en   (hq_wr_en),
        .wr_addr (hq_wr_addr),
        .wr_data (hq_wr_data),
        .rd_en   (hq_rd_en),
        .rd_addr (hq_head_reg),
        .rd_data (hq_rd_data)
    );

    mlqs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_PROCS)) u_low_queue (
        .clk     (clk),
        .wr_en   (lq_wr_en),
        .wr_addr (lq_wr_addr),
        .wr_data (lq_wr_data),
        .rd_en   (lq_rd_en),
        .rd_addr (lq_head_reg),
        .rd_data (lq_rd_data)
    );

    mlqs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_slot_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_length_reg  <= SLICE_RESET;
            current_time_reg  <= '0;
            running_slot_reg  <= '0;
            running_valid_reg <= 1'b0;
            running_level_reg <= LEVEL_HIGH;
            slice_used_reg    <= '0;
            busy_reg          <= '0;
            hq_head_reg       <= '0;
            hq_count_reg      <= '0;
            lq_head_reg       <= '0;
            lq_count_reg      <= '0;
            src_reg           <= SRC_NONE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            slice_length_reg  <= slice_length_next;
            current_time_reg  <= current_time_next;
            running_slot_reg  <= running_slot_next;
            running_valid_reg <= running_valid_next;
            running_level_reg <= running_level_next;
            slice_used_reg    <= slice_used_next;
            busy_reg          <= busy_next;
            hq_head_reg       <= hq_head_next;
            hq_count_reg      <= hq_count_next;
            lq_head_reg       <= lq_head_next;
            lq_count_reg      <= lq_count_next;
            src_reg           <= src_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

endmodule
